// ===== hdl/mmc3_pkg.sv =====
// ----------------------------------------------------------------------------
// mmc3_pkg: shared types and constants of the bank switching mapper
// Access kinds, memory targets, register indexes and controller handshakes.
// ----------------------------------------------------------------------------
package mmc3_pkg;

    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int TGT_W     = 2;
    localparam int MADDR_W   = 21;
    localparam int MIRROR_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int BANK_W    = 8;
    localparam int NUM_BANKS = 8;
    localparam int BSEL_W    = 3;
    localparam int PRG_OFF_W = 13;
    localparam int CHR_OFF_W = 10;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = 3;

    localparam logic [KIND_W-1:0] KIND_CPU_READ  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CPU_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PPU_READ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PPU_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SCANLINE  = 3'd4;

    localparam logic [TGT_W-1:0] TGT_NONE = 2'd0;
    localparam logic [TGT_W-1:0] TGT_PRG  = 2'd1;
    localparam logic [TGT_W-1:0] TGT_CHR  = 2'd2;

    localparam logic [MIRROR_W-1:0] MIRROR_VERTICAL    = 2'd0;
    localparam logic [MIRROR_W-1:0] MIRROR_FOUR_SCREEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MIRROR = 2'd3;

    // cpu register window, address bits 14:13 above 0x8000
    localparam logic [1:0] REG_BANK   = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_IRQ    = 2'd2;

    localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 9'd4;
    localparam logic [COUNT_W-1:0] CHR_COUNT_RESET = 9'd8;
    localparam logic [COUNT_W-1:0] MAX_BANKS       = 9'd256;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mod_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hdl/bank_switching_mapper_with_scanline_irq.sv =====
// ----------------------------------------------------------------------------
// bank_switching_mapper_with_scanline_irq: bank switching cartridge mapper
// Maps cpu and ppu accesses to program rom and pattern memory addresses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  s       | in        | s_valid / s_ready  | s_kind, s_address, s_write_value
//  m       | out       | m_valid / m_ready  | m_mem_target, m_mem_address, m_mem_write,
//          |           |                    | m_mem_write_value, m_irq, m_mirroring
//
//  one item at a time: cpu writes, ticks and accesses that map nowhere go from the
//  execute step straight to commit; a mapped memory access first steps through
//  the bit serial bank count remainder unit
//  synchronous active low reset restores the mapper registers and config defaults
//  a stalled result sits in the output register; the next item is taken meanwhile
//  and waits in commit until the output register drains
// ----------------------------------------------------------------------------
module bank_switching_mapper_with_scanline_irq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mmc3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmc3_pkg::COUNT_W-1:0]    cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mmc3_pkg::KIND_W-1:0]     s_kind,
    input  logic [mmc3_pkg::ADDR_W-1:0]     s_address,
    input  logic [mmc3_pkg::DATA_W-1:0]     s_write_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mmc3_pkg::TGT_W-1:0]      m_mem_target,
    output logic [mmc3_pkg::MADDR_W-1:0]    m_mem_address,
    output logic                            m_mem_write,
    output logic [mmc3_pkg::DATA_W-1:0]     m_mem_write_value,
    output logic                            m_irq,
    output logic [mmc3_pkg::MIRROR_W-1:0]   m_mirroring
);
    import mmc3_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mmc3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mmc3_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_kind            (s_kind),
        .s_address         (s_address),
        .s_write_value     (s_write_value),
        .cmd               (cmd),
        .status            (status),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_mem_target      (m_mem_target),
        .m_mem_address     (m_mem_address),
        .m_mem_write       (m_mem_write),
        .m_mem_write_value (m_mem_write_value),
        .m_irq             (m_irq),
        .m_mirroring       (m_mirroring)
    );

endmodule

// ===== hdl/mmc3_rem.sv =====
// ----------------------------------------------------------------------------
// mmc3_rem: bit serial remainder unit
// Reduces an 8-bit bank number modulo a bank count of 1 to 256, one bit a cycle while step is high.
// ----------------------------------------------------------------------------
module mmc3_rem (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          step,
    input  logic [mmc3_pkg::BANK_W-1:0]   dividend,
    input  logic [mmc3_pkg::COUNT_W-1:0]  divisor,
    output logic [mmc3_pkg::BANK_W-1:0]   remainder
);
    import mmc3_pkg::*;

    logic [BANK_W-1:0]  rem_reg;
    logic [BANK_W-1:0]  dvd_reg;
    logic [COUNT_W-1:0] trial;
    logic [COUNT_W-1:0] diff;
    logic [BANK_W-1:0]  rem_next;

    // partial remainder stays below the divisor, so it fits in 8 bits
    assign trial    = {rem_reg, dvd_reg[BANK_W-1]};
    assign diff     = trial - divisor;
    assign rem_next = (trial >= divisor) ? diff[BANK_W-1:0] : trial[BANK_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end else if (step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[BANK_W-2:0], 1'b0};
        end
    end

    assign remainder = rem_reg;

endmodule

// ===== hdl/mmc3_dp.sv =====
// ----------------------------------------------------------------------------
// mmc3_dp: mapper datapath
// Holds configuration and mapper registers, decodes accesses, owns result reg.
// ----------------------------------------------------------------------------
module mmc3_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mmc3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmc3_pkg::COUNT_W-1:0]    cfg_data,
    input  logic [mmc3_pkg::KIND_W-1:0]     s_kind,
    input  logic [mmc3_pkg::ADDR_W-1:0]     s_address,
    input  logic [mmc3_pkg::DATA_W-1:0]     s_write_value,
    input  mmc3_pkg::dp_cmd_t               cmd,
    output mmc3_pkg::dp_status_t            status,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [mmc3_pkg::TGT_W-1:0]      m_mem_target,
    output logic [mmc3_pkg::MADDR_W-1:0]    m_mem_address,
    output logic                            m_mem_write,
    output logic [mmc3_pkg::DATA_W-1:0]     m_mem_write_value,
    output logic                            m_irq,
    output logic [mmc3_pkg::MIRROR_W-1:0]   m_mirroring
);
    import mmc3_pkg::*;

    // configuration
    logic [COUNT_W-1:0]  prg_count_reg;
    logic [COUNT_W-1:0]  chr_count_reg;
    logic                chr_ram_reg;

    // mapper state
    logic [BSEL_W-1:0]   bank_sel_reg;
    logic                prg_swap_reg;
    logic                chr_invert_reg;
    logic [BANK_W-1:0]   bank_reg [NUM_BANKS];
    logic [MIRROR_W-1:0] mirror_reg;
    logic [BANK_W-1:0]   irq_reload_reg;
    logic [BANK_W-1:0]   irq_count_reg;
    logic                irq_pending_reg;
    logic                irq_enable_reg;

    // captured item and pending result
    logic [KIND_W-1:0]    kind_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [TGT_W-1:0]     pend_target_reg;
    logic [PRG_OFF_W-1:0] pend_off_reg;
    logic                 pend_wr_reg;
    logic [DATA_W-1:0]    pend_val_reg;
    logic                 pend_irq_reg;

    // result register
    logic                 m_valid_reg;
    logic [TGT_W-1:0]     m_target_reg;
    logic [MADDR_W-1:0]   m_address_reg;
    logic                 m_write_reg;
    logic [DATA_W-1:0]    m_value_reg;
    logic                 m_irq_reg;
    logic [MIRROR_W-1:0]  m_mirror_reg;

    logic [COUNT_W-1:0]   prg_cnt;
    logic [COUNT_W-1:0]   chr_cnt;
    logic [COUNT_W-1:0]   prg_last_w;
    logic [COUNT_W-1:0]   prg_second_w;
    logic [BANK_W-1:0]    prg_last;
    logic [BANK_W-1:0]    prg_second;
    logic [BANK_W-1:0]    prg_raw;
    logic [BSEL_W-1:0]    chr_win;
    logic [BSEL_W-1:0]    chr_idx;
    logic [BANK_W-1:0]    chr_raw;
    logic [TGT_W-1:0]     tgt;
    logic [BANK_W-1:0]    raw;
    logic [PRG_OFF_W-1:0] off;
    logic                 wr;
    logic                 even;
    logic                 reg_write;
    logic [BANK_W-1:0]    irq_count_next;
    logic                 irq_next;
    logic [COUNT_W-1:0]   divisor;
    logic [BANK_W-1:0]    remainder;
    logic [MIRROR_W-1:0]  mirror_cfg_next;
    logic [MADDR_W-1:0]   address_next;

    // counts above 256 behave as 256
    assign prg_cnt = (prg_count_reg > MAX_BANKS) ? MAX_BANKS : prg_count_reg;
    assign chr_cnt = (chr_count_reg > MAX_BANKS) ? MAX_BANKS : chr_count_reg;

    assign prg_last_w   = prg_cnt - 9'd1;
    assign prg_second_w = (prg_cnt >= 9'd2) ? (prg_cnt - 9'd2) : '0;
    assign prg_last     = prg_last_w[BANK_W-1:0];
    assign prg_second   = prg_second_w[BANK_W-1:0];

    always_comb begin
        case (addr_reg[14:13])
            2'd0:    prg_raw = prg_swap_reg ? prg_second : bank_reg[6];
            2'd1:    prg_raw = bank_reg[7];
            2'd2:    prg_raw = prg_swap_reg ? bank_reg[6] : prg_second;
            default: prg_raw = prg_last;
        endcase
    end

    assign chr_win = addr_reg[12:10] ^ {chr_invert_reg, 2'b00};
    assign chr_idx = chr_win - 3'd2;

    always_comb begin
        case (chr_win)
            3'd0, 3'd1: chr_raw = {bank_reg[0][BANK_W-1:1], chr_win[0]};
            3'd2, 3'd3: chr_raw = {bank_reg[1][BANK_W-1:1], chr_win[0]};
            default:    chr_raw = bank_reg[chr_idx];
        endcase
    end

    // access decode, valid while the controller is in its execute step
    always_comb begin
        tgt = TGT_NONE;
        raw = '0;
        off = '0;
        wr  = 1'b0;
        case (kind_reg)
            KIND_CPU_READ: begin
                if (addr_reg[15] && prg_cnt != '0) begin
                    tgt = TGT_PRG;
                    raw = prg_raw;
                    off = addr_reg[PRG_OFF_W-1:0];
                end
            end
            KIND_PPU_READ, KIND_PPU_WRITE: begin
                if (addr_reg[15:13] == 3'd0 && chr_cnt != '0 &&
                    (kind_reg == KIND_PPU_READ || chr_ram_reg)) begin
                    tgt = TGT_CHR;
                    raw = chr_raw;
                    off = {3'b000, addr_reg[CHR_OFF_W-1:0]};
                    wr  = (kind_reg == KIND_PPU_WRITE);
                end
            end
            default: ;
        endcase
    end

    assign even      = ~addr_reg[0];
    assign reg_write = cmd.exec && kind_reg == KIND_CPU_WRITE && addr_reg[15];

    // scanline counter: reload on zero or on request, else count down
    assign irq_count_next = (irq_count_reg == '0 || irq_pending_reg) ? irq_reload_reg
                                                                     : irq_count_reg - 8'd1;
    assign irq_next = (irq_count_next == '0) && irq_enable_reg;

    assign mirror_cfg_next = (cfg_data[1:0] >= MIRROR_FOUR_SCREEN) ? MIRROR_FOUR_SCREEN
                                                                    : cfg_data[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_count_reg   <= PRG_COUNT_RESET;
            chr_count_reg   <= CHR_COUNT_RESET;
            chr_ram_reg     <= 1'b0;
            bank_sel_reg    <= '0;
            prg_swap_reg    <= 1'b0;
            chr_invert_reg  <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++) begin
                bank_reg[i] <= '0;
            end
            mirror_reg      <= MIRROR_VERTICAL;
            irq_reload_reg  <= '0;
            irq_count_reg   <= '0;
            irq_pending_reg <= 1'b0;
            irq_enable_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRG_COUNT:   prg_count_reg <= cfg_data;
                    CFG_CHR_COUNT:   chr_count_reg <= cfg_data;
                    CFG_CHR_IS_RAM:  chr_ram_reg   <= cfg_data[0];
                    CFG_INIT_MIRROR: mirror_reg    <= mirror_cfg_next;
                    default: ;
                endcase
            end
            if (reg_write) begin
                case (addr_reg[14:13])
                    REG_BANK: begin
                        if (even) begin
                            bank_sel_reg   <= data_reg[BSEL_W-1:0];
                            prg_swap_reg   <= data_reg[6];
                            chr_invert_reg <= data_reg[7];
                        end else begin
                            bank_reg[bank_sel_reg] <= data_reg;
                        end
                    end
                    REG_MIRROR: begin
                        if (even && mirror_reg != MIRROR_FOUR_SCREEN) begin
                            mirror_reg <= {1'b0, data_reg[0]};
                        end
                    end
                    REG_IRQ: begin
                        if (even) begin
                            irq_reload_reg <= data_reg;
                        end else begin
                            irq_pending_reg <= 1'b1;
                        end
                    end
                    default: irq_enable_reg <= ~even;
                endcase
            end
            if (cmd.exec && kind_reg == KIND_SCANLINE) begin
                irq_count_reg   <= irq_count_next;
                irq_pending_reg <= 1'b0;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        case (pend_target_reg)
            TGT_PRG: address_next = {remainder, pend_off_reg};
            TGT_CHR: address_next = {3'b000, remainder, pend_off_reg[CHR_OFF_W-1:0]};
            default: address_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            addr_reg <= s_address;
            data_reg <= s_write_value;
        end
        if (cmd.exec) begin
            pend_target_reg <= tgt;
            pend_off_reg    <= off;
            pend_wr_reg     <= wr;
            pend_val_reg    <= wr ? data_reg : '0;
            pend_irq_reg    <= (kind_reg == KIND_SCANLINE) && irq_next;
        end
        if (cmd.commit) begin
            m_target_reg  <= pend_target_reg;
            m_address_reg <= address_next;
            m_write_reg   <= pend_wr_reg;
            m_value_reg   <= pend_val_reg;
            m_irq_reg     <= pend_irq_reg;
            m_mirror_reg  <= mirror_reg;
        end
    end

    assign divisor = (pend_target_reg == TGT_PRG) ? prg_cnt : chr_cnt;

    mmc3_rem u_rem (
        .aclk      (aclk),
        .load      (cmd.exec),
        .step      (cmd.mod_step),
        .dividend  (raw),
        .divisor   (divisor),
        .remainder (remainder)
    );

    assign status.need_mod = (tgt != TGT_NONE);
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid           = m_valid_reg;
    assign m_mem_target      = m_target_reg;
    assign m_mem_address     = m_address_reg;
    assign m_mem_write       = m_write_reg;
    assign m_mem_write_value = m_value_reg;
    assign m_irq             = m_irq_reg;
    assign m_mirroring       = m_mirror_reg;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before transfer");
    a_write_chr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_write_reg) |-> (m_target_reg == TGT_CHR))
        else $error("pattern write without pattern target");
    a_irq_no_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_irq_reg) |-> (m_target_reg == TGT_NONE))
        else $error("irq raised on a memory access");
`endif

endmodule

// ===== hdl/mmc3_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmc3_ctrl: mapper controller
// Sequences capture, decode, remainder steps and result commit per item.
// ----------------------------------------------------------------------------
module mmc3_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mmc3_pkg::dp_status_t  status,
    output mmc3_pkg::dp_cmd_t     cmd
);
    import mmc3_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    state_t            state_reg;
    logic              s_ready_reg;
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            step_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_EXEC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    step_reg  <= '0;
                    state_reg <= status.need_mod ? ST_DIVIDE : ST_COMMIT;
                end
                ST_DIVIDE: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    // wait for the result register to drain
                    if (!status.out_busy) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready      = s_ready_reg;
    assign cmd.capture  = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.mod_step = (state_reg == ST_DIVIDE);
    assign cmd.commit   = (state_reg == ST_COMMIT) && !status.out_busy;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready_reg) |=> (state_reg == ST_EXEC && !s_ready_reg))
        else $error("transfer not followed by execute step");
    a_divide_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && step_reg == LAST_STEP) |=> (state_reg == ST_COMMIT))
        else $error("remainder sequence length wrong");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
`endif

endmodule
